/* rtl/mer_pkg.sv */
// Shared widths, sequencer states and datapath selects for the midpoint ellipse rasterizer.
`default_nettype none

package mer_pkg;

    localparam int COORD_BITS  = 10;
    localparam int RADIUS_BITS = 9;

    localparam int PIX_W   = COORD_BITS + 2;
    localparam int RSQ_W   = 2 * RADIUS_BITS;
    localparam int TX_W    = COORD_BITS + 1;
    localparam int SQ_W    = 2 * TX_W;
    localparam int MUL_A_W = (SQ_W > RSQ_W) ? SQ_W : RSQ_W;
    localparam int MUL_B_W = (RSQ_W > TX_W) ? RSQ_W : TX_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SLOPE_W = RSQ_W + COORD_BITS + 2;
    localparam int DEC_W   = 48;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT_RX,
        ST_INIT_RY,
        ST_INIT_RXRY,
        ST_INIT_LOAD,
        ST_INIT_SUB,
        ST_INIT_ADD,
        ST_R2_TX,
        ST_R2_TY,
        ST_R2_RYTX,
        ST_R2_LOAD,
        ST_R2_ADD,
        ST_R2_SUB,
        ST_EMIT,
        ST_UPD,
        ST_ACC_DX,
        ST_ACC_DY,
        ST_ACC_RSQ
    } state_t;

    typedef enum logic [3:0] {
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RXSQ_RY,
        MUL_TX_TX,
        MUL_TY_TY,
        MUL_SQ_RYSQ,
        MUL_SQ_RXSQ,
        MUL_RXSQ_RYSQ
    } mul_sel_t;

    typedef enum logic [3:0] {
        ADD_RYSQ_X4,
        ADD_PROD_NEG_X4,
        ADD_RXSQ,
        ADD_PROD,
        ADD_PROD_X4,
        ADD_DX_X4,
        ADD_DY_NEG_X4,
        ADD_RSQ_X4
    } add_sel_t;

    typedef struct packed {
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     dec_en;
        logic     dec_clear;
        add_sel_t add_sel;
    } ctrl_t;

endpackage

`default_nettype wire

/* rtl/mer_if.sv */
// Handshake interfaces for the command and pixel channels.
`default_nettype none

interface mer_cmd_if import mer_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;

    modport source (output valid, command, center_x, center_y, radius_x, radius_y,
                    input ready);
    modport sink   (input valid, command, center_x, center_y, radius_x, radius_y,
                    output ready);
endinterface

interface mer_pix_if import mer_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    last_of_step;
    logic                    ellipse_done;

    modport source (output valid, pixel_x, pixel_y, last_of_step, ellipse_done,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_of_step, ellipse_done,
                    output ready);
endinterface

`default_nettype wire

/* rtl/midpoint_ellipse_rasterizer.sv */
// Midpoint ellipse rasterizer: sequencer around one shared multiplier and one decision adder.
//
// Channels: cmd (sink) takes one beat per command; pix (source) gives pixel beats.
// A start beat (command 0) loads center and radii; it emits nothing and runs
// the multiply/accumulate sequence before the block is ready again.
// A start abandons any ellipse in progress.
// A step beat (command 1) emits the four mirrored points (+x,+y), (-x,+y),
// (+x,-y), (-x,-y), one per cycle while the receiver takes them, last_of_step
// on the fourth, then advances the position and decision. The step that
// crosses into region two first runs the five squared terms through the
// shared multiplier before it emits its points.
// The step that emits the final point (y = 0 in region two) flags every beat
// with ellipse_done and leaves the block idle; a step while idle is dropped.
// cmd.ready is high only in the idle state. When the receiver stalls, the
// current point holds on pix until taken. Reset (rst_n low, asynchronous)
// returns the sequencer to idle with no ellipse loaded.
`default_nettype none

module midpoint_ellipse_rasterizer import mer_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    mer_cmd_if.sink   cmd,
    mer_pix_if.source pix
);

    state_t               state_reg, state_next;
    logic [1:0]           k_reg, k_next;
    logic                 busy_reg, busy_next;
    ctrl_t                ctrl;

    logic [COORD_BITS-1:0]  center_col_reg, center_row_reg;
    logic [RADIUS_BITS-1:0] rx_in_reg, ry_in_reg;
    logic [RSQ_W-1:0]       rx_sq_reg, ry_sq_reg;
    logic [COORD_BITS-1:0]  offset_x_reg, offset_y_reg;
    logic [SLOPE_W-1:0]     slope_dx_reg, slope_dy_reg;
    logic [DEC_W-1:0]       decision_reg, decision_next;
    logic [SQ_W-1:0]        sq_reg;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic                   region2_reg;
    logic                   move_x_reg, move_y_reg;

    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [DEC_W-1:0]       addend;
    logic [COORD_BITS-1:0]  ty_mag;
    logic                   cmd_fire, pix_fire;
    logic                   need_r2, done_flag, diag;
    logic [PIX_W-1:0]       cx, cy, ox, oy;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign pix_fire  = pix.valid && pix.ready;
    assign need_r2   = !region2_reg && !(slope_dx_reg < slope_dy_reg);
    assign done_flag = region2_reg && (offset_y_reg == '0);
    // region two moves diagonally unless the decision is strictly positive
    assign diag = region2_reg ? (decision_reg[DEC_W-1] || (decision_reg == '0))
                              : !decision_reg[DEC_W-1];
    assign ty_mag = (offset_y_reg == '0) ? COORD_BITS'(1) : offset_y_reg - 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.command == CMD_START)
                        state_next = ST_INIT_RX;
                    else if (busy_reg)
                        state_next = need_r2 ? ST_R2_TX : ST_EMIT;
                end
            end
            ST_INIT_RX:   state_next = ST_INIT_RY;
            ST_INIT_RY:   state_next = ST_INIT_RXRY;
            ST_INIT_RXRY: state_next = ST_INIT_LOAD;
            ST_INIT_LOAD: state_next = ST_INIT_SUB;
            ST_INIT_SUB:  state_next = ST_INIT_ADD;
            ST_INIT_ADD:  state_next = ST_IDLE;
            ST_R2_TX:     state_next = ST_R2_TY;
            ST_R2_TY:     state_next = ST_R2_RYTX;
            ST_R2_RYTX:   state_next = ST_R2_LOAD;
            ST_R2_LOAD:   state_next = ST_R2_ADD;
            ST_R2_ADD:    state_next = ST_R2_SUB;
            ST_R2_SUB:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (pix.ready && (k_reg == 2'd3))
                    state_next = done_flag ? ST_IDLE : ST_UPD;
            end
            ST_UPD:       state_next = ST_ACC_DX;
            ST_ACC_DX:    state_next = ST_ACC_DY;
            ST_ACC_DY:    state_next = ST_ACC_RSQ;
            ST_ACC_RSQ:   state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        ctrl           = '{mul_en: 1'b0, mul_sel: MUL_RX_RX, dec_en: 1'b0,
                           dec_clear: 1'b0, add_sel: ADD_PROD};
        cmd.ready      = 1'b0;
        pix.valid      = 1'b0;
        unique case (state_reg)
            ST_IDLE:      cmd.ready = 1'b1;
            ST_INIT_RX:   begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_RX_RX;   end
            ST_INIT_RY:   begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_RY_RY;   end
            ST_INIT_RXRY: begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_RXSQ_RY; end
            ST_INIT_LOAD:
            begin
                ctrl.dec_en    = 1'b1;
                ctrl.dec_clear = 1'b1;
                ctrl.add_sel   = ADD_RYSQ_X4;
            end
            ST_INIT_SUB:  begin ctrl.dec_en = 1'b1; ctrl.add_sel = ADD_PROD_NEG_X4; end
            ST_INIT_ADD:  begin ctrl.dec_en = 1'b1; ctrl.add_sel = ADD_RXSQ;        end
            ST_R2_TX:     begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_TX_TX;   end
            ST_R2_TY:     begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_TY_TY;   end
            ST_R2_RYTX:   begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_SQ_RYSQ; end
            ST_R2_LOAD:
            begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_sel   = MUL_SQ_RXSQ;
                ctrl.dec_en    = 1'b1;
                ctrl.dec_clear = 1'b1;
                ctrl.add_sel   = ADD_PROD;
            end
            ST_R2_ADD:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_RXSQ_RYSQ;
                ctrl.dec_en  = 1'b1;
                ctrl.add_sel = ADD_PROD_X4;
            end
            ST_R2_SUB:    begin ctrl.dec_en = 1'b1; ctrl.add_sel = ADD_PROD_NEG_X4; end
            ST_EMIT:      pix.valid = 1'b1;
            ST_UPD:       ;
            ST_ACC_DX:    begin ctrl.dec_en = 1'b1; ctrl.add_sel = ADD_DX_X4;     end
            ST_ACC_DY:    begin ctrl.dec_en = 1'b1; ctrl.add_sel = ADD_DY_NEG_X4; end
            ST_ACC_RSQ:   begin ctrl.dec_en = 1'b1; ctrl.add_sel = ADD_RSQ_X4;    end
            default:      ;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (state_reg == ST_IDLE)
        begin
            k_next = '0;
            if (cmd_fire && (cmd.command == CMD_START))
                busy_next = 1'b1;
        end
        else if (state_reg == ST_EMIT && pix_fire)
        begin
            k_next = k_reg + 1'b1;
            if ((k_reg == 2'd3) && done_flag)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            busy_reg  <= busy_next;
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.mul_sel)
            MUL_RX_RX:     begin mul_a = MUL_A_W'(rx_in_reg); mul_b = MUL_B_W'(rx_in_reg); end
            MUL_RY_RY:     begin mul_a = MUL_A_W'(ry_in_reg); mul_b = MUL_B_W'(ry_in_reg); end
            MUL_RXSQ_RY:   begin mul_a = MUL_A_W'(rx_sq_reg); mul_b = MUL_B_W'(ry_in_reg); end
            MUL_TX_TX:
            begin
                mul_a = MUL_A_W'({offset_x_reg, 1'b1});
                mul_b = MUL_B_W'({offset_x_reg, 1'b1});
            end
            MUL_TY_TY:     begin mul_a = MUL_A_W'(ty_mag); mul_b = MUL_B_W'(ty_mag); end
            MUL_SQ_RYSQ:   begin mul_a = MUL_A_W'(sq_reg); mul_b = MUL_B_W'(ry_sq_reg); end
            MUL_SQ_RXSQ:   begin mul_a = MUL_A_W'(sq_reg); mul_b = MUL_B_W'(rx_sq_reg); end
            MUL_RXSQ_RYSQ: begin mul_a = MUL_A_W'(rx_sq_reg); mul_b = MUL_B_W'(ry_sq_reg); end
            default:       ;
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // decision adder
    always_comb
    begin
        addend = '0;
        unique case (ctrl.add_sel)
            ADD_RYSQ_X4:     addend = DEC_W'({ry_sq_reg, 2'b00});
            ADD_PROD_NEG_X4: addend = -DEC_W'({prod_reg, 2'b00});
            ADD_RXSQ:        addend = DEC_W'(rx_sq_reg);
            ADD_PROD:        addend = DEC_W'(prod_reg);
            ADD_PROD_X4:     addend = DEC_W'({prod_reg, 2'b00});
            ADD_DX_X4:       addend = move_x_reg ? DEC_W'({slope_dx_reg, 2'b00}) : '0;
            ADD_DY_NEG_X4:   addend = move_y_reg ? -DEC_W'({slope_dy_reg, 2'b00}) : '0;
            ADD_RSQ_X4:      addend = region2_reg ? DEC_W'({rx_sq_reg, 2'b00})
                                                  : DEC_W'({ry_sq_reg, 2'b00});
            default:         ;
        endcase
        decision_next = (ctrl.dec_clear ? DEC_W'(0) : decision_reg) + addend;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            prod_reg <= prod_next;
        if (ctrl.dec_en)
            decision_reg <= decision_next;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.command == CMD_START))
                begin
                    center_col_reg <= cmd.center_x;
                    center_row_reg <= cmd.center_y;
                    rx_in_reg      <= cmd.radius_x;
                    ry_in_reg      <= cmd.radius_y;
                    offset_x_reg   <= '0;
                    offset_y_reg   <= COORD_BITS'(cmd.radius_y);
                    slope_dx_reg   <= '0;
                    region2_reg    <= 1'b0;
                end
            end
            ST_INIT_RY:   rx_sq_reg <= RSQ_W'(prod_reg);
            ST_INIT_RXRY: ry_sq_reg <= RSQ_W'(prod_reg);
            ST_INIT_LOAD: slope_dy_reg <= SLOPE_W'({prod_reg, 1'b0});
            ST_R2_TX:     region2_reg <= 1'b1;
            ST_R2_TY:     sq_reg <= SQ_W'(prod_reg);
            ST_R2_RYTX:   sq_reg <= SQ_W'(prod_reg);
            ST_UPD:
            begin
                move_x_reg <= !region2_reg || diag;
                move_y_reg <= region2_reg || diag;
                if (!region2_reg || diag)
                begin
                    offset_x_reg <= offset_x_reg + 1'b1;
                    slope_dx_reg <= slope_dx_reg + SLOPE_W'({ry_sq_reg, 1'b0});
                end
                if (region2_reg || diag)
                begin
                    offset_y_reg <= offset_y_reg - 1'b1;
                    slope_dy_reg <= slope_dy_reg - SLOPE_W'({rx_sq_reg, 1'b0});
                end
            end
            default:      ;
        endcase
    end

    // mirrored point for the current beat: bit 0 of k negates x, bit 1 negates y
    assign cx = PIX_W'(center_col_reg);
    assign cy = PIX_W'(center_row_reg);
    assign ox = PIX_W'(offset_x_reg);
    assign oy = PIX_W'(offset_y_reg);

    assign pix.pixel_x      = $signed(k_reg[0] ? (cx - ox) : (cx + ox));
    assign pix.pixel_y      = $signed(k_reg[1] ? (cy - oy) : (cy + oy));
    assign pix.last_of_step = (k_reg == 2'd3);
    assign pix.ellipse_done = done_flag;

endmodule

`default_nettype wire
